### hw/rtl/pews_pkg.sv
// Shared types, command codes, register indexes and saturation helper for the particle core.
`default_nettype none

package pews_pkg;

   // Command codes carried by each input item
   localparam logic [2:0] CMD_LOAD_POS = 3'd0;
   localparam logic [2:0] CMD_LOAD_VEL = 3'd1;
   localparam logic [2:0] CMD_ACCEL    = 3'd2;
   localparam logic [2:0] CMD_FORCE    = 3'd3;
   localparam logic [2:0] CMD_MOVE     = 3'd4;
   localparam logic [2:0] CMD_WALL     = 3'd5;

   // Configuration register indexes (byte address is 4 * index)
   localparam logic [2:0] REG_MASS_RECIP = 3'd0;
   localparam logic [2:0] REG_ELASTICITY = 3'd1;
   localparam logic [2:0] REG_SIZE       = 3'd2;
   localparam logic [2:0] REG_GRID_X     = 3'd3;
   localparam logic [2:0] REG_GRID_Y     = 3'd4;
   localparam logic [2:0] REG_GRID_Z     = 3'd5;

   localparam int NUM_AXES = 3;

   // Control from the sequencer to each axis lane
   typedef struct packed {
      logic [2:0] cmd;
      logic       force_on;
      logic       mul_en;
      logic       upd_en;
      logic       cell_en;
   } lane_ctrl_type;

   // Per-axis configuration seen by a lane
   typedef struct packed {
      logic [16:0] elasticity;
      logic [30:0] size;
      logic [14:0] grid;
   } lane_cfg_type;

   // Per-axis state presented to the merge stage
   typedef struct packed {
      logic signed [31:0] pos;
      logic signed [31:0] vel;
      logic signed [15:0] cell_idx;
   } lane_res_type;

   // Clamp a wide signed sum to 32 bit signed
   function automatic logic signed [31:0] sat32(input logic signed [49:0] x);
      logic signed [31:0] r;
      if (!x[49] && (|x[48:31])) begin
         r = 32'sh7fff_ffff;
      end else if (x[49] && !(&x[48:31])) begin
         r = 32'sh8000_0000;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/pews_lane.sv
// One axis lane: holds position, velocity and cell of its axis and runs multiply and update.
`default_nettype none

module pews_lane (
   input  wire                     clock,
   input  wire                     reset,
   input  wire pews_pkg::lane_ctrl_type ctrl,
   input  wire pews_pkg::lane_cfg_type  cfg,
   input  wire signed [31:0]       vec,
   input  wire        [31:0]       factor,
   output pews_pkg::lane_res_type  res
);
   import pews_pkg::*;

   logic signed [31:0] pos_ff, pos_in;
   logic signed [31:0] vel_ff, vel_in;
   logic signed [15:0] cell_ff, cell_rnd;
   logic signed [64:0] prod_a_ff, prod_a_in;
   logic signed [52:0] prod_b_ff, prod_b_in;
   logic               hit_lo_ff, hit_lo_in;
   logic               hit_hi_ff, hit_hi_in;

   logic signed [34:0] p35, s35, g35, lo_diff, hi_diff, wall_gap;
   logic signed [31:0] op_a;
   logic        [31:0] fac;

   logic signed [49:0] fa50, fb50, pos50, vel50, s50, g50;
   logic signed [49:0] v_sum, p_sum, v_neg, p_lo, p_hi;

   logic        [32:0] mag;
   logic        [33:0] rsum;
   logic        [16:0] rq, rq_neg;

   // Wall tests and multiplier operands
   always_comb begin
      p35       = {{3{pos_ff[31]}}, pos_ff};
      s35       = {4'b0, cfg.size};
      g35       = {4'b0, cfg.grid, 16'b0};
      lo_diff   = p35 - s35;
      hi_diff   = p35 + s35 - g35;
      hit_lo_in = lo_diff[34] || (lo_diff == 35'sd0);
      hit_hi_in = !hit_lo_in && !hi_diff[34];
      wall_gap  = hit_lo_in ? (s35 - p35) : hi_diff;
      op_a      = ((ctrl.cmd == CMD_MOVE) || (ctrl.cmd == CMD_WALL)) ? vel_ff : vec;
      fac       = (ctrl.cmd == CMD_WALL) ? {15'b0, cfg.elasticity} : factor;
      prod_a_in = op_a * $signed({1'b0, fac});
      prod_b_in = $signed({1'b0, cfg.elasticity}) * wall_gap;
   end

   // Register products and wall hits
   always_ff @(posedge clock) begin
      if (ctrl.mul_en) begin
         prod_a_ff <= prod_a_in;
         prod_b_ff <= prod_b_in;
         hit_lo_ff <= hit_lo_in;
         hit_hi_ff <= hit_hi_in;
      end
   end

   // Floor-shift products and form saturating sums
   always_comb begin
      fa50  = {prod_a_ff[64], prod_a_ff[64:16]};
      fb50  = {{13{prod_b_ff[52]}}, prod_b_ff[52:16]};
      pos50 = {{18{pos_ff[31]}}, pos_ff};
      vel50 = {{18{vel_ff[31]}}, vel_ff};
      s50   = {19'b0, cfg.size};
      g50   = {19'b0, cfg.grid, 16'b0};
      v_sum = vel50 + fa50;
      p_sum = pos50 + fa50;
      v_neg = 50'sd0 - fa50;
      p_lo  = s50 + fb50;
      p_hi  = g50 - s50 - fb50;

      pos_in = pos_ff;
      vel_in = vel_ff;
      case (ctrl.cmd)
         CMD_LOAD_POS: begin
            pos_in = vec;
         end
         CMD_LOAD_VEL: begin
            vel_in = vec;
         end
         CMD_ACCEL: begin
            vel_in = sat32(v_sum);
         end
         CMD_FORCE: begin
            if (ctrl.force_on) begin
               vel_in = sat32(v_sum);
            end
         end
         CMD_MOVE: begin
            pos_in = sat32(p_sum);
         end
         CMD_WALL: begin
            if (hit_lo_ff) begin
               pos_in = sat32(p_lo);
               vel_in = sat32(v_neg);
            end else if (hit_hi_ff) begin
               pos_in = sat32(p_hi);
               vel_in = sat32(v_neg);
            end
         end
         default: begin
            pos_in = pos_ff;
            vel_in = vel_ff;
         end
      endcase
   end

   // Round position half away from zero into a cell, clamp to 16 bit
   always_comb begin
      mag    = pos_ff[31] ? (33'd0 - {pos_ff[31], pos_ff}) : {1'b0, pos_ff};
      rsum   = {1'b0, mag} + 34'd32768;
      rq     = rsum[32:16];
      rq_neg = 17'd0 - rq;
      if (pos_ff[31]) begin
         cell_rnd = rq_neg[15:0];
      end else if (rq[16] || rq[15]) begin
         cell_rnd = 16'sh7fff;
      end else begin
         cell_rnd = rq[15:0];
      end
   end

   // Hold axis state
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         vel_ff  <= '0;
         cell_ff <= '0;
      end else begin
         if (ctrl.upd_en) begin
            pos_ff <= pos_in;
            vel_ff <= vel_in;
         end
         if (ctrl.cell_en) begin
            cell_ff <= cell_rnd;
         end
      end
   end

   assign res.pos      = pos_ff;
   assign res.vel      = vel_ff;
   assign res.cell_idx = (ctrl.cmd == CMD_WALL) ? cell_rnd : cell_ff;

endmodule

`default_nettype wire

### hw/rtl/pews_merge.sv
// Merge stage: gathers the three lane states into the held result register.
`default_nettype none

module pews_merge (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         load,
   input  wire pews_pkg::lane_res_type lane_res [3],
   input  wire                         rsp_stall,
   output logic                        rsp_valid,
   output pews_pkg::lane_res_type      rsp_res [3],
   output logic                        free
);
   import pews_pkg::*;

   logic         valid_ff;
   lane_res_type res_ff [NUM_AXES];

   // Output register is free when empty or its transfer completes now
   assign free = !valid_ff || !rsp_stall;

   // Track result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
   end

   // Capture all lanes together
   always_ff @(posedge clock) begin
      if (load) begin
         for (int k = 0; k < NUM_AXES; k++) begin
            res_ff[k] <= lane_res[k];
         end
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_res   = res_ff;

endmodule

`default_nettype wire

### hw/rtl/particle_euler_step_with_wall_bounce_core.sv
// Top level of the particle integrator: register port, sequencer, three axis lanes, merge.
`default_nettype none

// Explicit Euler particle integrator with elastic wall bounce, signed Q16.16 throughout.
// Three lanes, one per axis, run the same multiply and saturating update side by side;
// a merge stage packs their state into one held result per item. One item is in work at a
// time: it passes the states idle, multiply, update and result, and its result is loaded
// in the result state once the output is free; a force item first passes the factor
// state, since the time step times reciprocal mass factor is formed and registered ahead
// of the lane multiply. A result still waiting at the output does not block the next
// transfer in, only the next result load. All state is ready directly after reset; the
// user must write configuration over the register port while idle (not enforced here).

module particle_euler_step_with_wall_bounce_core (
   input  wire               clock,
   input  wire               reset,
   // input channel
   input  wire               req_valid,
   output logic              req_stall,
   input  wire        [2:0]  req_cmd,
   input  wire signed [31:0] req_vec_x,
   input  wire signed [31:0] req_vec_y,
   input  wire signed [31:0] req_vec_z,
   input  wire        [31:0] req_time_step,
   // result channel
   output logic              rsp_valid,
   input  wire               rsp_stall,
   output logic signed [31:0] rsp_pos_x,
   output logic signed [31:0] rsp_pos_y,
   output logic signed [31:0] rsp_pos_z,
   output logic signed [31:0] rsp_vel_x,
   output logic signed [31:0] rsp_vel_y,
   output logic signed [31:0] rsp_vel_z,
   output logic signed [15:0] rsp_cell_x,
   output logic signed [15:0] rsp_cell_y,
   output logic signed [15:0] rsp_cell_z,
   // configuration port
   input  wire               csr_psel,
   input  wire               csr_penable,
   input  wire               csr_pwrite,
   input  wire        [4:0]  csr_paddr,
   input  wire        [31:0] csr_pwdata,
   output logic       [31:0] csr_prdata,
   output logic              csr_pready
);
   import pews_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_FACT = 5'b00010,
      S_MUL  = 5'b00100,
      S_UPD  = 5'b01000,
      S_DONE = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic [31:0] mass_recip_ff;
   logic [16:0] elasticity_ff;
   logic [30:0] size_ff;
   logic [14:0] grid_ff [NUM_AXES];

   logic               [2:0]  cmd_ff;
   logic signed        [31:0] vec_ff [NUM_AXES];
   logic               [31:0] dt_ff;
   logic               [31:0] t_ff, t_in;
   logic               [63:0] t_prod;
   logic               [31:0] factor;

   logic          csr_wr;
   logic [2:0]    csr_idx;
   logic          req_xfer;
   logic          out_free;
   logic          out_load;
   lane_ctrl_type lane_ctrl;
   lane_cfg_type  lane_cfg [NUM_AXES];
   lane_res_type  lane_res [NUM_AXES];
   lane_res_type  out_res  [NUM_AXES];

   // Register port
   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[4:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         mass_recip_ff <= '0;
         elasticity_ff <= 17'd65536;
         size_ff       <= '0;
         for (int k = 0; k < NUM_AXES; k++) begin
            grid_ff[k] <= 15'd64;
         end
      end else if (csr_wr) begin
         case (csr_idx)
            REG_MASS_RECIP: mass_recip_ff <= csr_pwdata;
            REG_ELASTICITY: elasticity_ff <= csr_pwdata[16:0];
            REG_SIZE:       size_ff       <= csr_pwdata[30:0];
            REG_GRID_X:     grid_ff[0]    <= csr_pwdata[14:0];
            REG_GRID_Y:     grid_ff[1]    <= csr_pwdata[14:0];
            REG_GRID_Z:     grid_ff[2]    <= csr_pwdata[14:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_MASS_RECIP: csr_prdata = mass_recip_ff;
         REG_ELASTICITY: csr_prdata = {15'b0, elasticity_ff};
         REG_SIZE:       csr_prdata = {1'b0, size_ff};
         REG_GRID_X:     csr_prdata = {17'b0, grid_ff[0]};
         REG_GRID_Y:     csr_prdata = {17'b0, grid_ff[1]};
         REG_GRID_Z:     csr_prdata = {17'b0, grid_ff[2]};
         default:        csr_prdata = '0;
      endcase
   end

   // Input transfer only while idle
   assign req_stall = (state_ff != S_IDLE);
   assign req_xfer  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         cmd_ff    <= req_cmd;
         vec_ff[0] <= req_vec_x;
         vec_ff[1] <= req_vec_y;
         vec_ff[2] <= req_vec_z;
         dt_ff     <= req_time_step;
      end
   end

   // Force factor: time step times reciprocal mass, clamped to unsigned 32 bit
   assign t_prod = dt_ff * mass_recip_ff;
   assign t_in   = (|t_prod[63:48]) ? 32'hffff_ffff : t_prod[47:16];

   always_ff @(posedge clock) begin
      if (state_ff == S_FACT) begin
         t_ff <= t_in;
      end
   end

   assign factor = (cmd_ff == CMD_FORCE) ? t_ff : dt_ff;

   // Sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               state_in = (req_cmd == CMD_FORCE) ? S_FACT : S_MUL;
            end
         end
         S_FACT: state_in = S_MUL;
         S_MUL:  state_in = S_UPD;
         S_UPD:  state_in = S_DONE;
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign out_load = (state_ff == S_DONE) && out_free;

   always_comb begin
      lane_ctrl.cmd      = cmd_ff;
      lane_ctrl.force_on = (mass_recip_ff != 32'd0);
      lane_ctrl.mul_en   = (state_ff == S_MUL);
      lane_ctrl.upd_en   = (state_ff == S_UPD);
      lane_ctrl.cell_en  = out_load && (cmd_ff == CMD_WALL);
   end

   // Axis lanes
   for (genvar k = 0; k < NUM_AXES; k++) begin : g_lane
      always_comb begin
         lane_cfg[k].elasticity = elasticity_ff;
         lane_cfg[k].size       = size_ff;
         lane_cfg[k].grid       = grid_ff[k];
      end

      pews_lane u_lane (
         .clock  (clock),
         .reset  (reset),
         .ctrl   (lane_ctrl),
         .cfg    (lane_cfg[k]),
         .vec    (vec_ff[k]),
         .factor (factor),
         .res    (lane_res[k])
      );
   end

   // Merge lanes into the result register
   pews_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .load      (out_load),
      .lane_res  (lane_res),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_res   (out_res),
      .free      (out_free)
   );

   assign rsp_pos_x  = out_res[0].pos;
   assign rsp_pos_y  = out_res[1].pos;
   assign rsp_pos_z  = out_res[2].pos;
   assign rsp_vel_x  = out_res[0].vel;
   assign rsp_vel_y  = out_res[1].vel;
   assign rsp_vel_z  = out_res[2].vel;
   assign rsp_cell_x = out_res[0].cell_idx;
   assign rsp_cell_y = out_res[1].cell_idx;
   assign rsp_cell_z = out_res[2].cell_idx;

   // Result load never overwrites a result that is still stalled
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      out_load |-> (!rsp_valid || !rsp_stall))
      else $error("result loaded over a stalled result");

   // Axis position and velocity move only in the update step or on reset (checked on x and z position and y velocity)
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_UPD) |=> ($stable(lane_res[0].pos) && $stable(lane_res[1].vel)
                               && $stable(lane_res[2].pos)))
      else $error("axis state changed outside update step");

   // A result appears only after the result step
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == S_DONE))
      else $error("result valid without a finished item");

endmodule

`default_nettype wire
